/* src/bounded_stack_with_keyed_removal_defines.svh */
// Assertion macros for the bounded stack with keyed removal.
`ifndef BOUNDED_STACK_WITH_KEYED_REMOVAL_DEFINES_SVH
`define BOUNDED_STACK_WITH_KEYED_REMOVAL_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BSK_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bsk assertion failed");
// next-cycle implication
`define BSK_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsk assertion failed");
`else
`define BSK_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define BSK_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* src/bsk_pkg.sv */
// Shared types, sizes and action codes for the bounded stack.
package bsk_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int KEY_W  = 32;
	localparam int CAP_W  = 5;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [CAP_W-1:0]  cap_t;
	typedef logic [1:0]        action_t;

	localparam cap_t CAP_RESET = cap_t'(16);

	// request codes
	localparam action_t ACT_PUSH  = 2'd0;
	localparam action_t ACT_POP   = 2'd1;
	localparam action_t ACT_DEL   = 2'd2;
	localparam action_t ACT_QUERY = 2'd3;

	// RAM port requests
	typedef struct packed {
		logic  en;
		addr_t addr;
		key_t  data;
	} wr_req_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} rd_req_t;

endpackage

/* src/bsk_ram.sv */
// Entry storage: one write port, one read port with registered read data.
module bsk_ram import bsk_pkg::*; (
	input  logic    clk,
	input  wr_req_t wr,
	input  rd_req_t rd,
	output key_t    rd_data
);

	key_t mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

/* src/bounded_stack_with_keyed_removal.sv */
// Top level: request sequencer, top-of-stack copy, result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_stall   | action, key_value
//  out     | output    | out_valid/out_stall | success, top_value, top_valid, entry_count
//  cfg     | input     | cfg_valid/cfg_ready | capacity_limit
//
// Pop reads the new top back from the RAM when entries remain. Query walks the RAM
// from the top down, one entry per cycle. Delete adds a shift pass of one entry per
// cycle over the newer entries.
// The single RAM read port sets this pace. Reset empties the store at once.
// A new transaction is taken while the previous result still waits at the output.
`include "bounded_stack_with_keyed_removal_defines.svh"

module bounded_stack_with_keyed_removal import bsk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  action_t                 action,
	input  logic signed [KEY_W-1:0] key_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    success,
	output logic signed [KEY_W-1:0] top_value,
	output logic                    top_valid,
	output cnt_t                    entry_count,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  cap_t                    capacity_limit
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_POP_RD = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;

	logic [2:0] state_q, state_d;
	cnt_t       count_q, count_d;
	key_t       top_q, top_d;
	addr_t      idx_q, idx_d;
	logic       ok_q, ok_d;
	action_t    act_q, act_d;
	key_t       key_q, key_d;
	cap_t       cap_q;

	logic       out_valid_q;
	logic       success_q;
	key_t       top_out_q;
	logic       top_valid_q;
	cnt_t       count_out_q;

	wr_req_t    wr;
	rd_req_t    rd;
	key_t       rd_data;
	logic       out_load;
	logic       push_room;
	logic       idx_is_top;
	logic       shift_last;

	bsk_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ST_IDLE);
	assign push_room  = (int'(count_q) < int'(cap_q)) && (int'(count_q) < DEPTH);
	assign idx_is_top = (cnt_t'(idx_q) + cnt_t'(1)) == count_q;
	assign shift_last = (cnt_t'(idx_q) + cnt_t'(2)) == count_q;

	// sequencer: RAM read, compare, write back
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		top_d    = top_q;
		idx_d    = idx_q;
		ok_d     = ok_q;
		act_d    = act_q;
		key_d    = key_q;
		wr       = '0;
		rd       = '0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					act_d   = action;
					key_d   = key_t'(key_value);
					ok_d    = 1'b0;
					state_d = ST_FIN;
					case (action)
						ACT_PUSH: begin
							if (push_room) begin
								wr.en   = 1'b1;
								wr.addr = addr_t'(count_q);
								wr.data = key_t'(key_value);
								count_d = count_q + cnt_t'(1);
								top_d   = key_t'(key_value);
								ok_d    = 1'b1;
							end
						end
						ACT_POP: begin
							if (count_q != '0) begin
								count_d = count_q - cnt_t'(1);
								ok_d    = 1'b1;
								if (count_q > cnt_t'(1)) begin
									rd.en   = 1'b1;
									rd.addr = addr_t'(count_q - cnt_t'(2));
									state_d = ST_POP_RD;
								end
							end
						end
						default: begin
							// delete or query: walk down from the top
							if (count_q != '0) begin
								rd.en   = 1'b1;
								rd.addr = addr_t'(count_q - cnt_t'(1));
								idx_d   = addr_t'(count_q - cnt_t'(1));
								state_d = ST_SCAN;
							end
						end
					endcase
				end
			end
			ST_POP_RD: begin
				top_d   = rd_data;
				state_d = ST_FIN;
			end
			ST_SCAN: begin
				if (rd_data == key_q) begin
					ok_d    = 1'b1;
					state_d = ST_FIN;
					if (act_q == ACT_DEL) begin
						if (idx_is_top) begin
							// removing the top works like a pop
							count_d = count_q - cnt_t'(1);
							if (count_q > cnt_t'(1)) begin
								rd.en   = 1'b1;
								rd.addr = addr_t'(count_q - cnt_t'(2));
								state_d = ST_POP_RD;
							end
						end else begin
							rd.en   = 1'b1;
							rd.addr = idx_q + addr_t'(1);
							state_d = ST_SHIFT;
						end
					end
				end else if (idx_q == '0) begin
					state_d = ST_FIN;
				end else begin
					rd.en   = 1'b1;
					rd.addr = idx_q - addr_t'(1);
					idx_d   = idx_q - addr_t'(1);
				end
			end
			ST_SHIFT: begin
				// move entry idx+1 down to idx; top stays the same
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = rd_data;
				if (shift_last) begin
					count_d = count_q - cnt_t'(1);
					state_d = ST_FIN;
				end else begin
					rd.en   = 1'b1;
					rd.addr = idx_q + addr_t'(2);
					idx_d   = idx_q + addr_t'(1);
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_valid) begin
				cap_q <= capacity_limit;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		top_q <= top_d;
		idx_q <= idx_d;
		ok_q  <= ok_d;
		act_q <= act_d;
		key_q <= key_d;
		if (out_load) begin
			success_q   <= ok_q;
			top_valid_q <= (count_q != '0);
			top_out_q   <= (count_q != '0) ? top_q : '0;
			count_out_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign success     = success_q;
	assign top_value   = signed'(top_out_q);
	assign top_valid   = top_valid_q;
	assign entry_count = count_out_q;

	// checks
	`BSK_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, int'(count_q) <= DEPTH)
	`BSK_ASSERT_NEXT(a_push_grows, clk, arst_n,
		state_q == ST_IDLE && in_valid && action == ACT_PUSH && push_room,
		count_q == $past(count_q) + cnt_t'(1))
	`BSK_ASSERT_IMPLY(a_shift_in_range, clk, arst_n, state_q == ST_SHIFT, (cnt_t'(idx_q) + cnt_t'(1)) < count_q)
	`BSK_ASSERT_IMPLY(a_top_flag, clk, arst_n, out_valid, top_valid == (entry_count != '0))

endmodule
